// File: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a consequent holds in the cycle after its antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/psct_pkg.sv
`timescale 1ns / 1ps

package psct_pkg;

    localparam int unsigned ADDR_W = 24;
    localparam int unsigned LEN_W  = 13;

    localparam logic [1:0] CFG_PAGE_SIZE_LOG2  = 2'd0;
    localparam logic [1:0] CFG_MAX_CHUNK_BYTES = 2'd1;
    localparam logic [1:0] CFG_INTERFACE_MODE  = 2'd2;

    localparam logic KIND_START  = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    localparam logic RESULT_CHUNK = 1'b0;
    localparam logic RESULT_DONE  = 1'b1;

    localparam logic [1:0] MODE_SPI       = 2'd0;
    localparam logic [1:0] MODE_QUAD_DATA = 2'd1;
    localparam logic [1:0] MODE_QPI       = 2'd2;

    localparam logic [7:0] OP_READ_FAST  = 8'h0B;
    localparam logic [7:0] OP_READ_QUAD  = 8'hEB;
    localparam logic [7:0] OP_WRITE      = 8'h02;
    localparam logic [7:0] OP_WRITE_QUAD = 8'h38;

    localparam logic [1:0] DUMMY_NONE      = 2'd0;
    localparam logic [1:0] DUMMY_SPI       = 2'd1;
    localparam logic [1:0] DUMMY_QUAD_DATA = 2'd3;
    localparam logic [1:0] DUMMY_QPI       = 2'd2;

    localparam logic [3:0]       PAGE_LOG2_MIN   = 4'd4;
    localparam logic [3:0]       PAGE_LOG2_MAX   = 4'd12;
    localparam logic [3:0]       PAGE_LOG2_RESET = 4'd10;
    localparam logic [LEN_W-1:0] CHUNK_MIN       = 13'd4;
    localparam logic [LEN_W-1:0] CHUNK_MAX       = 13'd4096;
    localparam logic [LEN_W-1:0] CHUNK_RESET     = 13'd1024;

    typedef struct packed {
        logic [3:0]       page_size_log2;
        logic [LEN_W-1:0] max_chunk_bytes;
        logic [1:0]       interface_mode;
    } cfg_t;

endpackage

// File: hw/rtl/psct_if.sv
`timescale 1ns / 1ps

interface psct_req_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic                        is_write;
    logic [psct_pkg::ADDR_W-1:0] start_address;
    logic [psct_pkg::ADDR_W-1:0] length;

    modport source (output valid, output kind, output is_write, output start_address,
                    output length, input ready);
    modport sink   (input valid, input kind, input is_write, input start_address,
                    input length, output ready);
endinterface

interface psct_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        result_kind;
    logic [7:0]                  opcode;
    logic [1:0]                  line_mode;
    logic [1:0]                  dummy_count;
    logic [psct_pkg::ADDR_W-1:0] chunk_address;
    logic [psct_pkg::LEN_W-1:0]  chunk_length;
    logic                        chunk_is_write;

    modport source (output valid, output result_kind, output opcode, output line_mode,
                    output dummy_count, output chunk_address, output chunk_length,
                    output chunk_is_write, input ready);
    modport sink   (input valid, input result_kind, input opcode, input line_mode,
                    input dummy_count, input chunk_address, input chunk_length,
                    input chunk_is_write, output ready);
endinterface

// File: hw/rtl/psct_chunk.sv
`timescale 1ns / 1ps

module psct_chunk
(
    input  psct_pkg::cfg_t                cfg,
    input  logic [psct_pkg::ADDR_W-1:0]   address,
    input  logic [psct_pkg::ADDR_W-1:0]   bytes_left,
    output logic [psct_pkg::LEN_W-1:0]    chunk_length
);

    logic [3:0]                  page_log2;
    logic [psct_pkg::LEN_W-1:0]  limit;
    logic [psct_pkg::LEN_W-1:0]  page_bytes;
    logic [psct_pkg::LEN_W-1:0]  offset;
    logic [psct_pkg::LEN_W-1:0]  room;
    logic [psct_pkg::LEN_W-1:0]  capped;

    always_comb
    begin
        if (cfg.page_size_log2 < psct_pkg::PAGE_LOG2_MIN)
        begin
            page_log2 = psct_pkg::PAGE_LOG2_MIN;
        end
        else if (cfg.page_size_log2 > psct_pkg::PAGE_LOG2_MAX)
        begin
            page_log2 = psct_pkg::PAGE_LOG2_MAX;
        end
        else
        begin
            page_log2 = cfg.page_size_log2;
        end

        if (cfg.max_chunk_bytes < psct_pkg::CHUNK_MIN)
        begin
            limit = psct_pkg::CHUNK_MIN;
        end
        else if (cfg.max_chunk_bytes > psct_pkg::CHUNK_MAX)
        begin
            limit = psct_pkg::CHUNK_MAX;
        end
        else
        begin
            limit = cfg.max_chunk_bytes;
        end

        page_bytes = psct_pkg::LEN_W'(1) << page_log2;
        offset     = address[psct_pkg::LEN_W-1:0] & (page_bytes - psct_pkg::LEN_W'(1));
        room       = page_bytes - offset;
        capped     = (room > limit) ? limit : room;

        if (bytes_left < {{(psct_pkg::ADDR_W - psct_pkg::LEN_W){1'b0}}, capped})
        begin
            chunk_length = bytes_left[psct_pkg::LEN_W-1:0];
        end
        else
        begin
            chunk_length = capped;
        end
    end

endmodule

// File: hw/rtl/psram_chunked_transfer_sequencer.sv
`timescale 1ns / 1ps
// Channel   Role    Payload
// req       sink    kind, is_write, start_address, length
// rsp       source  result_kind, opcode, line_mode, dummy_count, chunk_address,
//                   chunk_length, chunk_is_write
// One transfer on req per cycle unless rsp stalls; each that causes a result reaches rsp
// via the input and result registers; the rate is set by the single compute stage between them.
// Reset clears the transfer state and loads page 1024 bytes, chunk 1024, SPI mode.
// A stall on rsp holds the result register; req stays ready while it can drain.
// Transfers that cause no result leave without waiting for the result register.

`include "assert_macros.svh"

module psram_chunked_transfer_sequencer
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [psct_pkg::LEN_W-1:0]    cfg_data,
    psct_req_if.sink                      req,
    psct_rsp_if.source                    rsp
);

    localparam int unsigned AW = psct_pkg::ADDR_W;
    localparam int unsigned LW = psct_pkg::LEN_W;

    psct_pkg::cfg_t cfg_reg;

    logic          s1_valid_reg;
    logic          s1_kind_reg;
    logic          s1_is_write_reg;
    logic [AW-1:0] s1_address_reg;
    logic [AW-1:0] s1_length_reg;

    logic          active_reg;
    logic          active_next;
    logic          writing_reg;
    logic          writing_next;
    logic [AW-1:0] next_address_reg;
    logic [AW-1:0] next_address_next;
    logic [AW-1:0] bytes_left_reg;
    logic [AW-1:0] bytes_left_next;
    logic [LW-1:0] last_len_reg;
    logic [LW-1:0] last_len_next;

    logic          out_valid_reg;
    logic          out_kind_reg;
    logic          out_kind_next;
    logic [7:0]    out_opcode_reg;
    logic [7:0]    out_opcode_next;
    logic [1:0]    out_mode_reg;
    logic [1:0]    out_mode_next;
    logic [1:0]    out_dummy_reg;
    logic [1:0]    out_dummy_next;
    logic [AW-1:0] out_address_reg;
    logic [LW-1:0] out_length_reg;
    logic [LW-1:0] out_length_next;
    logic          out_write_reg;

    logic          start_take;
    logic          finish_take;
    logic          emit;
    logic          s1_advance;
    logic          done;
    logic [AW-1:0] last_len_ext;
    logic [AW-1:0] sum_address;
    logic [AW-1:0] left_after;
    logic [AW-1:0] cur_address;
    logic [AW-1:0] cur_left;
    logic          cur_write;
    logic [1:0]    mode_eff;
    logic [LW-1:0] chunk_len;

    psct_chunk u_chunk
    (
        .cfg          (cfg_reg),
        .address      (cur_address),
        .bytes_left   (cur_left),
        .chunk_length (chunk_len)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.page_size_log2  <= psct_pkg::PAGE_LOG2_RESET;
            cfg_reg.max_chunk_bytes <= psct_pkg::CHUNK_RESET;
            cfg_reg.interface_mode  <= psct_pkg::MODE_SPI;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                psct_pkg::CFG_PAGE_SIZE_LOG2:  cfg_reg.page_size_log2  <= cfg_data[3:0];
                psct_pkg::CFG_MAX_CHUNK_BYTES: cfg_reg.max_chunk_bytes <= cfg_data;
                psct_pkg::CFG_INTERFACE_MODE:  cfg_reg.interface_mode  <= cfg_data[1:0];
                default:                       cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        start_take   = s1_valid_reg && (s1_kind_reg == psct_pkg::KIND_START) && !active_reg;
        finish_take  = s1_valid_reg && (s1_kind_reg == psct_pkg::KIND_FINISH) && active_reg;
        emit         = start_take || finish_take;
        s1_advance   = s1_valid_reg && (!emit || !out_valid_reg || rsp.ready);

        last_len_ext = {{(AW - LW){1'b0}}, last_len_reg};
        sum_address  = next_address_reg + last_len_ext;
        left_after   = (bytes_left_reg >= last_len_ext) ? (bytes_left_reg - last_len_ext)
                                                        : '0;
        cur_address  = start_take ? s1_address_reg  : sum_address;
        cur_left     = start_take ? s1_length_reg   : left_after;
        cur_write    = start_take ? s1_is_write_reg : writing_reg;
        done         = (cur_left == '0);
        mode_eff     = (cfg_reg.interface_mode > psct_pkg::MODE_QPI) ? psct_pkg::MODE_QPI
                                                                     : cfg_reg.interface_mode;
    end

    always_comb
    begin
        active_next       = active_reg;
        writing_next      = writing_reg;
        next_address_next = next_address_reg;
        bytes_left_next   = bytes_left_reg;
        last_len_next     = last_len_reg;
        if (s1_advance && emit)
        begin
            active_next       = !done;
            writing_next      = cur_write;
            next_address_next = cur_address;
            bytes_left_next   = cur_left;
            last_len_next     = done ? last_len_reg : chunk_len;
        end
    end

    always_comb
    begin
        out_kind_next   = done ? psct_pkg::RESULT_DONE : psct_pkg::RESULT_CHUNK;
        out_opcode_next = 8'h00;
        out_mode_next   = psct_pkg::MODE_SPI;
        out_dummy_next  = psct_pkg::DUMMY_NONE;
        out_length_next = '0;
        if (!done)
        begin
            out_mode_next   = mode_eff;
            out_length_next = chunk_len;
            if (cur_write)
            begin
                out_opcode_next = (mode_eff == psct_pkg::MODE_QUAD_DATA) ?
                                  psct_pkg::OP_WRITE_QUAD : psct_pkg::OP_WRITE;
            end
            else
            begin
                case (mode_eff)
                    psct_pkg::MODE_SPI:
                    begin
                        out_opcode_next = psct_pkg::OP_READ_FAST;
                        out_dummy_next  = psct_pkg::DUMMY_SPI;
                    end
                    psct_pkg::MODE_QUAD_DATA:
                    begin
                        out_opcode_next = psct_pkg::OP_READ_QUAD;
                        out_dummy_next  = psct_pkg::DUMMY_QUAD_DATA;
                    end
                    default:
                    begin
                        out_opcode_next = psct_pkg::OP_READ_QUAD;
                        out_dummy_next  = psct_pkg::DUMMY_QPI;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            active_reg       <= 1'b0;
            writing_reg      <= 1'b0;
            next_address_reg <= '0;
            bytes_left_reg   <= '0;
            last_len_reg     <= '0;
        end
        else
        begin
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (s1_advance && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            active_reg       <= active_next;
            writing_reg      <= writing_next;
            next_address_reg <= next_address_next;
            bytes_left_reg   <= bytes_left_next;
            last_len_reg     <= last_len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_kind_reg     <= req.kind;
            s1_is_write_reg <= req.is_write;
            s1_address_reg  <= req.start_address;
            s1_length_reg   <= req.length;
        end
        if (s1_advance && emit)
        begin
            out_kind_reg    <= out_kind_next;
            out_opcode_reg  <= out_opcode_next;
            out_mode_reg    <= out_mode_next;
            out_dummy_reg   <= out_dummy_next;
            out_address_reg <= cur_address;
            out_length_reg  <= out_length_next;
            out_write_reg   <= cur_write;
        end
    end

    assign req.ready          = !s1_valid_reg || s1_advance;
    assign rsp.valid          = out_valid_reg;
    assign rsp.result_kind    = out_kind_reg;
    assign rsp.opcode         = out_opcode_reg;
    assign rsp.line_mode      = out_mode_reg;
    assign rsp.dummy_count    = out_dummy_reg;
    assign rsp.chunk_address  = out_address_reg;
    assign rsp.chunk_length   = out_length_reg;
    assign rsp.chunk_is_write = out_write_reg;

    `ASSERT_ALWAYS(active_has_bytes, !(active_reg && (bytes_left_reg == '0)), "active with no bytes left")
    `ASSERT_IMPLIES(chunk_within_left, active_reg, (last_len_reg != '0) && (last_len_ext <= bytes_left_reg), "chunk length out of range")
    `ASSERT_IMPLIES(chunk_nonzero, out_valid_reg && (out_kind_reg == psct_pkg::RESULT_CHUNK), out_length_reg != '0, "empty chunk command")
    `ASSERT_IMPLIES(done_is_clean, out_valid_reg && (out_kind_reg == psct_pkg::RESULT_DONE), (out_opcode_reg == 8'h00) && (out_length_reg == '0), "done result carries command data")
    `ASSERT_NEXT(start_goes_active, s1_advance && start_take && !done, active_reg, "started transfer not active")

endmodule
